// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes of the first-fit heap allocator: request functions,
// result status codes and the command/status groups between control and data.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NOFIT = 2'd1;
    localparam t_status ST_ZERO  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

    localparam int REQ_W    = 15;
    localparam int STATUS_W = 2;

    typedef struct packed {
        logic    capture;
        logic    mul;
        logic    init;
        logic    start_walk;
        logic    step;
        logic    wr_hdr;
        logic    wr_split;
        logic    rd_free;
        logic    wr_free;
        logic    set_result;
        t_status res_code;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic zero;
        logic too_big;
        logic range_bad;
        logic broken;
        logic fit;
        logic split;
        logic last_block;
    } t_dp_sts;

endpackage

// ===== sv/ffha_if.sv =====
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels of the allocator: requests in, results out.
// ----------------------------------------------------------------------------
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [14:0] request_bytes;
    logic [14:0] block_offset;

    modport source (output valid, func, request_bytes, block_offset, input ready);
    modport sink   (input valid, func, request_bytes, block_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [14:0] payload_offset;
    logic [1:0]  status;

    modport source (output valid, payload_offset, status, input ready);
    modport sink   (input valid, payload_offset, status, output ready);
endinterface

// ===== sv/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator over a single-port header memory, no coalescing.
// ----------------------------------------------------------------------------
// One request is in flight at a time. An allocate captures the request,
// converts the size to words, checks it, reads one block header per step on
// the walk from word 0 and writes the chosen header, then a split header when
// the chosen block is split; the header walk through the single memory port
// makes latency grow with fragmentation. A free reads and rewrites the freed
// block's header; a zero-size, too-large or out-of-range request ends at the
// check. A new request is taken while the previous result still waits on the
// output. After reset the initial whole-heap header is written before any request.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
    parameter int HEAP_WORDS = 4096,
    parameter int WORD_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ffha_dp #(
        .HEAP_WORDS (HEAP_WORDS),
        .WORD_BYTES (WORD_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_func           (i_req.func),
        .i_request_bytes  (i_req.request_bytes),
        .i_block_offset   (i_req.block_offset),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_payload_offset (o_rsp.payload_offset),
        .o_status         (o_rsp.status)
    );

endmodule

// ===== sv/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer of the allocator: accepts a request, steps the datapath through
// size conversion, header walk or free update, and hands off the result.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_SPLIT = 3'd5;
    localparam logic [2:0] S_FREE  = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_dp_cmd    w_cmd;

    always_comb begin
        n_state    = r_state;
        w_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                w_cmd.init = 1'b1;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (i_sts.func == FUNC_ALLOC) begin
                    priority if (i_sts.zero) begin
                        w_cmd.set_result = 1'b1;
                        w_cmd.res_code   = ST_ZERO;
                        n_state          = S_RESP;
                    end else if (i_sts.too_big) begin
                        w_cmd.set_result = 1'b1;
                        w_cmd.res_code   = ST_NOFIT;
                        n_state          = S_RESP;
                    end else begin
                        w_cmd.start_walk = 1'b1;
                        n_state          = S_WALK;
                    end
                end else begin
                    if (i_sts.range_bad) begin
                        w_cmd.set_result = 1'b1;
                        w_cmd.res_code   = ST_RANGE;
                        n_state          = S_RESP;
                    end else begin
                        w_cmd.rd_free = 1'b1;
                        n_state       = S_FREE;
                    end
                end
            end
            S_WALK: begin
                priority if (i_sts.broken) begin
                    w_cmd.set_result = 1'b1;
                    w_cmd.res_code   = ST_NOFIT;
                    n_state          = S_RESP;
                end else if (i_sts.fit) begin
                    w_cmd.wr_hdr     = 1'b1;
                    w_cmd.set_result = 1'b1;
                    w_cmd.res_code   = ST_OK;
                    n_state          = i_sts.split ? S_SPLIT : S_RESP;
                end else if (i_sts.last_block) begin
                    w_cmd.set_result = 1'b1;
                    w_cmd.res_code   = ST_NOFIT;
                    n_state          = S_RESP;
                end else begin
                    w_cmd.step = 1'b1;
                end
            end
            S_SPLIT: begin
                w_cmd.wr_split = 1'b1;
                n_state        = S_RESP;
            end
            S_FREE: begin
                w_cmd.wr_free    = 1'b1;
                w_cmd.set_result = 1'b1;
                w_cmd.res_code   = ST_OK;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_split_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_split |-> $past(w_cmd.wr_hdr))
        else $error("split header written without a preceding header write");
    a_step_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> (!i_sts.broken && !i_sts.fit && !i_sts.last_block))
        else $error("walk advanced past a terminal header");
    a_hdr_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_hdr |-> (i_sts.fit && !i_sts.broken))
        else $error("header claimed without a fitting free block");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule

// ===== sv/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath of the allocator: request registers, reciprocal multiply for the
// word conversion, walk pointer, header memory port and result registers.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; #(
    parameter int HEAP_WORDS = 4096,
    parameter int WORD_BYTES = 8
) (
    input  logic                i_clk,
    input  logic                i_func,
    input  logic [REQ_W-1:0]    i_request_bytes,
    input  logic [REQ_W-1:0]    i_block_offset,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic [REQ_W-1:0]    o_payload_offset,
    output logic [STATUS_W-1:0] o_status
);

    localparam int AW     = $clog2(HEAP_WORDS);
    localparam int SW     = $clog2(HEAP_WORDS + 1);
    localparam int HW     = SW + 1;
    localparam int DVW    = REQ_W + 1;
    localparam int DIV_SH = DVW + $clog2(WORD_BYTES);
    localparam int RECIP  = ((2 ** DIV_SH) + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RW     = $clog2(RECIP + 1);
    localparam int PW     = DVW + RW;
    localparam int QW     = PW - DIV_SH;

    logic                r_func;
    logic [REQ_W-1:0]    r_bytes;
    logic [REQ_W-1:0]    r_offset;
    logic [PW-1:0]       r_prod;
    logic [SW-1:0]       r_pos;
    logic [SW-1:0]       r_need;
    logic [SW-1:0]       r_rest;
    logic [AW-1:0]       r_faddr;
    logic [REQ_W-1:0]    r_res_offset;
    t_status             r_res_status;
    logic [REQ_W-1:0]    r_out_offset;
    t_status             r_out_status;

    logic [DVW-1:0]      w_dividend;
    logic [QW-1:0]       w_q;
    logic [QW:0]         w_need_full;
    logic [HW-1:0]       w_rdata;
    logic [SW-1:0]       w_size;
    logic                w_used;
    logic [SW-1:0]       w_rest;
    logic [SW-1:0]       w_pos_next;
    logic [31:0]         w_off_full;
    logic                w_we;
    logic                w_re;
    logic [AW-1:0]       w_addr;
    logic [HW-1:0]       w_wdata;

    assign w_dividend = (r_func == FUNC_ALLOC)
                      ? DVW'(r_bytes) + DVW'(WORD_BYTES - 1)
                      : DVW'(r_offset);
    assign w_q         = r_prod[PW-1:DIV_SH];
    assign w_need_full = {1'b0, w_q} + (QW + 1)'(1);

    assign w_size     = w_rdata[SW-1:0];
    assign w_used     = w_rdata[HW-1];
    assign w_rest     = w_size - r_need;
    assign w_pos_next = r_pos + w_size;
    assign w_off_full = (32'(r_pos) + 32'd1) * 32'(WORD_BYTES);

    always_comb begin
        o_sts            = '0;
        o_sts.func       = r_func;
        o_sts.zero       = (r_bytes == '0);
        o_sts.too_big    = 32'(w_need_full) > 32'(HEAP_WORDS);
        o_sts.range_bad  = (w_q == '0) || (32'(w_q) > 32'(HEAP_WORDS));
        o_sts.broken     = (w_size == '0)
                        || (32'(w_size) > (32'(HEAP_WORDS) - 32'(r_pos)));
        o_sts.fit        = !w_used && (w_size >= r_need);
        o_sts.split      = (w_rest >= SW'(2));
        o_sts.last_block = 32'(w_pos_next) >= 32'(HEAP_WORDS);
    end

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_addr  = r_pos[AW-1:0];
        w_wdata = '0;
        priority if (i_cmd.init) begin
            w_we    = 1'b1;
            w_addr  = '0;
            w_wdata = {1'b0, SW'(HEAP_WORDS)};
        end else if (i_cmd.start_walk) begin
            w_re   = 1'b1;
            w_addr = '0;
        end else if (i_cmd.step) begin
            w_re   = 1'b1;
            w_addr = w_pos_next[AW-1:0];
        end else if (i_cmd.wr_hdr) begin
            w_we    = 1'b1;
            w_addr  = r_pos[AW-1:0];
            w_wdata = {1'b1, o_sts.split ? r_need : w_size};
        end else if (i_cmd.wr_split) begin
            w_we    = 1'b1;
            w_addr  = AW'(r_pos + r_need);
            w_wdata = {1'b0, r_rest};
        end else if (i_cmd.rd_free) begin
            w_re   = 1'b1;
            w_addr = AW'(w_q - QW'(1));
        end else if (i_cmd.wr_free) begin
            w_we    = 1'b1;
            w_addr  = r_faddr;
            w_wdata = {1'b0, w_size};
        end else begin
            w_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_bytes  <= i_request_bytes;
            r_offset <= i_block_offset;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(w_dividend) * PW'(RECIP);
        end
        if (i_cmd.start_walk) begin
            r_pos  <= '0;
            r_need <= SW'(w_need_full);
        end
        if (i_cmd.step) begin
            r_pos <= w_pos_next;
        end
        if (i_cmd.wr_hdr) begin
            r_rest <= w_rest;
        end
        if (i_cmd.rd_free) begin
            r_faddr <= AW'(w_q - QW'(1));
        end
        if (i_cmd.set_result) begin
            r_res_status <= i_cmd.res_code;
            r_res_offset <= (i_cmd.res_code == ST_OK && r_func == FUNC_ALLOC)
                          ? w_off_full[REQ_W-1:0] : '0;
        end
        if (i_cmd.out_load) begin
            r_out_offset <= r_res_offset;
            r_out_status <= r_res_status;
        end
    end

    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign o_payload_offset = r_out_offset;
    assign o_status         = r_out_status;

endmodule
